@@ rtl/fic_pkg.sv @@
// Shared types, step codes and the control store of the inversion counter.
package fic_pkg;

    localparam int VAL_W   = 8;
    localparam int GB_W    = 12;
    localparam int TOTAL_W = 23;
    localparam int STEP_W  = 4;

    localparam logic [GB_W-1:0]    GB_MAX    = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef logic [STEP_W-1:0] step_t;

    // Program addresses
    localparam step_t STEP_WAIT  = 4'd0;
    localparam step_t STEP_CHK   = 4'd1;
    localparam step_t STEP_QUERY = 4'd2;
    localparam step_t STEP_QEND  = 4'd3;
    localparam step_t STEP_CALC  = 4'd4;
    localparam step_t STEP_UPD   = 4'd5;
    localparam step_t STEP_TOTAL = 4'd6;
    localparam step_t STEP_EMIT  = 4'd7;
    localparam step_t STEP_NEXT  = 4'd8;
    localparam step_t STEP_CLR   = 4'd9;
    localparam step_t STEP_SWEEP = 4'd10;
    localparam step_t STEP_BACK  = 4'd11;

    typedef enum logic [3:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_NO_ITEM,
        COND_FULL,
        COND_POS_NZ,
        COND_IN_RANGE,
        COND_OUT_BUSY,
        COND_NOT_LAST,
        COND_SWEEP_MORE
    } cond_t;

    typedef enum logic [2:0] {
        POS_HOLD,
        POS_DOWN,
        POS_UP,
        POS_SLOT,
        POS_ZERO,
        POS_INC
    } pos_op_t;

    typedef struct packed {
        logic    take;
        pos_op_t pos_op;
        logic    rd_q;
        logic    rd_u;
        logic    calc;
        logic    add_total;
        logic    emit;
        logic    clear;
        logic    sweep_wr;
        cond_t   cond;
        step_t   target;
    } ctrl_t;

    typedef struct packed {
        logic no_item;
        logic full;
        logic pos_nz;
        logic in_range;
        logic out_busy;
        logic last;
        logic sweep_more;
    } status_t;

    // Control store: one word per program step
    function automatic ctrl_t fic_ucode(input step_t step);
        ctrl_t w;
        w        = '0;
        w.pos_op = POS_HOLD;
        w.cond   = COND_NONE;
        w.target = STEP_WAIT;
        case (step)
            STEP_WAIT: begin
                w.take   = 1'b1;
                w.cond   = COND_NO_ITEM;
                w.target = STEP_WAIT;
            end
            STEP_CHK: begin
                w.cond   = COND_FULL;
                w.target = STEP_TOTAL;
            end
            STEP_QUERY: begin
                w.rd_q   = 1'b1;
                w.pos_op = POS_DOWN;
                w.cond   = COND_POS_NZ;
                w.target = STEP_QUERY;
            end
            STEP_QEND: begin
                w.pos_op = POS_SLOT;
            end
            STEP_CALC: begin
                w.calc = 1'b1;
            end
            STEP_UPD: begin
                w.rd_u   = 1'b1;
                w.pos_op = POS_UP;
                w.cond   = COND_IN_RANGE;
                w.target = STEP_UPD;
            end
            STEP_TOTAL: begin
                w.add_total = 1'b1;
            end
            STEP_EMIT: begin
                w.emit   = 1'b1;
                w.cond   = COND_OUT_BUSY;
                w.target = STEP_EMIT;
            end
            STEP_NEXT: begin
                w.cond   = COND_NOT_LAST;
                w.target = STEP_WAIT;
            end
            STEP_CLR: begin
                w.clear  = 1'b1;
                w.pos_op = POS_ZERO;
            end
            STEP_SWEEP: begin
                w.sweep_wr = 1'b1;
                w.pos_op   = POS_INC;
                w.cond     = COND_SWEEP_MORE;
                w.target   = STEP_SWEEP;
            end
            STEP_BACK: begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_WAIT;
            end
            default: begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_CLR;
            end
        endcase
        return w;
    endfunction

endpackage

@@ rtl/fic_seq.sv @@
// Step counter and control store lookup with conditional jumps.
module fic_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  fic_pkg::status_t status,
    output fic_pkg::ctrl_t   ctrl,
    output fic_pkg::step_t   step
);
    import fic_pkg::*;

    step_t step_reg;
    step_t step_next;
    logic  jump;

    always_comb
    begin
        ctrl = fic_ucode(step_reg);
        case (ctrl.cond)
            COND_NONE:       jump = 1'b0;
            COND_ALWAYS:     jump = 1'b1;
            COND_NO_ITEM:    jump = status.no_item;
            COND_FULL:       jump = status.full;
            COND_POS_NZ:     jump = status.pos_nz;
            COND_IN_RANGE:   jump = status.in_range;
            COND_OUT_BUSY:   jump = status.out_busy;
            COND_NOT_LAST:   jump = ~status.last;
            COND_SWEEP_MORE: jump = status.sweep_more;
            default:         jump = 1'b0;
        endcase
        step_next = jump ? ctrl.target : step_reg + step_t'(1);
    end

    // Start with the clearing pass over the tree
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_CLR;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    assign step = step_reg;

endmodule

@@ rtl/fic_tree_ram.sv @@
// Count tree storage: one write port, one registered read port.
module fic_tree_ram #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 13
) (
    input  logic              clk,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/fic_datapath.sv @@
// Datapath: tree index walk, prefix accumulator, counters and output register.
module fic_datapath #(
    parameter int VALUE_BITS = 8,
    parameter int MAX_LEN    = 4096,
    parameter int CNT_W      = $clog2(MAX_LEN + 1)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  fic_pkg::ctrl_t                 ctrl,
    output fic_pkg::status_t               status,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [fic_pkg::VAL_W-1:0]      value,
    input  logic                           is_last,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [fic_pkg::GB_W-1:0]       greater_before,
    output logic [fic_pkg::TOTAL_W-1:0]    inversion_total,
    output logic                           is_last_res,
    output logic                           overflow,
    output logic [VALUE_BITS-1:0]          ram_rd_addr,
    input  logic [CNT_W-1:0]               ram_rd_data,
    output logic                           ram_wr_en,
    output logic [VALUE_BITS-1:0]          ram_wr_addr,
    output logic [CNT_W-1:0]               ram_wr_data
);
    import fic_pkg::*;

    localparam int SLOTS = 2 ** VALUE_BITS;
    localparam int POS_W = VALUE_BITS + 2;
    localparam int SUM_W = TOTAL_W + 1;
    localparam int GBX_W = (CNT_W > GB_W) ? CNT_W : GB_W;

    localparam logic [POS_W-1:0] SLOTS_P  = POS_W'(SLOTS);
    localparam logic [VAL_W-1:0] VAL_MASK = VAL_W'(SLOTS - 1);
    localparam logic [CNT_W-1:0] LEN_MAX  = CNT_W'(MAX_LEN);

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [POS_W-1:0]   slot_reg, slot_next;
    logic [POS_W-1:0]   prev_pos_reg, prev_pos_next;
    logic [CNT_W-1:0]   acc_reg, acc_next;
    logic [CNT_W-1:0]   greater_reg, greater_next;
    logic [CNT_W-1:0]   items_reg, items_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic               ovf_reg, ovf_next;
    logic               last_reg, last_next;
    logic               acc_pend_reg, acc_pend_next;
    logic               wr_pend_reg, wr_pend_next;
    logic               out_valid_reg, out_valid_next;
    logic [GB_W-1:0]    out_gb_reg, out_gb_next;
    logic [TOTAL_W-1:0] out_total_reg, out_total_next;
    logic               out_last_reg, out_last_next;
    logic               out_ovf_reg, out_ovf_next;

    logic               accept;
    logic               full;
    logic               out_busy;
    logic [POS_W-1:0]   pos_low;
    logic [POS_W-1:0]   pos_dn;
    logic [POS_W-1:0]   pos_up;
    logic [POS_W-1:0]   slot_in;
    logic [SUM_W-1:0]   total_sum;
    logic [GBX_W-1:0]   gb_wide;
    logic [GB_W-1:0]    gb_sat;

    assign in_ready = ctrl.take;
    assign accept   = ctrl.take & in_valid;
    assign full     = items_reg >= LEN_MAX;
    assign out_busy = out_valid_reg & ~out_ready;

    // Lowest set bit drives both tree walks
    assign pos_low = pos_reg & (~pos_reg + POS_W'(1));
    assign pos_dn  = pos_reg - pos_low;
    assign pos_up  = pos_reg + pos_low;
    assign slot_in = POS_W'(value & VAL_MASK) + POS_W'(1);

    assign total_sum = {1'b0, total_reg} + SUM_W'(greater_reg);
    assign gb_wide   = GBX_W'(greater_reg);
    assign gb_sat    = (gb_wide > GBX_W'(GB_MAX)) ? GB_MAX : GB_W'(gb_wide);

    always_comb
    begin
        status.no_item    = ~accept;
        status.full       = full;
        status.pos_nz     = pos_dn != '0;
        status.in_range   = pos_up <= SLOTS_P;
        status.out_busy   = out_busy;
        status.last       = last_reg;
        status.sweep_more = pos_reg[VALUE_BITS-1:0] != '1;
    end

    always_comb
    begin
        case (ctrl.pos_op)
            POS_HOLD: pos_next = pos_reg;
            POS_DOWN: pos_next = pos_dn;
            POS_UP:   pos_next = pos_up;
            POS_SLOT: pos_next = slot_reg;
            POS_ZERO: pos_next = '0;
            POS_INC:  pos_next = pos_reg + POS_W'(1);
            default:  pos_next = pos_reg;
        endcase

        slot_next     = slot_reg;
        last_next     = last_reg;
        acc_next      = acc_reg;
        greater_next  = greater_reg;
        items_next    = items_reg;
        total_next    = total_reg;
        ovf_next      = ovf_reg;
        prev_pos_next = ctrl.rd_u ? pos_reg : prev_pos_reg;
        acc_pend_next = ctrl.rd_q;
        wr_pend_next  = ctrl.rd_u;

        // Read data of a query read lands in the cycle after it
        if (acc_pend_reg)
        begin
            acc_next = acc_reg + ram_rd_data;
        end

        if (accept)
        begin
            slot_next    = slot_in;
            pos_next     = slot_in;
            last_next    = is_last;
            acc_next     = '0;
            greater_next = '0;
            if (full)
            begin
                ovf_next = 1'b1;
            end
        end

        if (ctrl.calc)
        begin
            greater_next = items_reg - acc_reg;
            items_next   = items_reg + CNT_W'(1);
        end

        if (ctrl.add_total)
        begin
            total_next = (total_sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX
                                                          : total_sum[TOTAL_W-1:0];
        end

        if (ctrl.clear)
        begin
            items_next = '0;
            total_next = '0;
            ovf_next   = 1'b0;
        end

        out_valid_next = out_valid_reg & ~out_ready;
        out_gb_next    = out_gb_reg;
        out_total_next = out_total_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        if (ctrl.emit && !out_busy)
        begin
            out_valid_next = 1'b1;
            out_gb_next    = gb_sat;
            out_total_next = total_reg;
            out_last_next  = last_reg;
            out_ovf_next   = ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            items_reg     <= '0;
            total_reg     <= '0;
            ovf_reg       <= 1'b0;
            acc_pend_reg  <= 1'b0;
            wr_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            items_reg     <= items_next;
            total_reg     <= total_next;
            ovf_reg       <= ovf_next;
            acc_pend_reg  <= acc_pend_next;
            wr_pend_reg   <= wr_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        slot_reg      <= slot_next;
        prev_pos_reg  <= prev_pos_next;
        acc_reg       <= acc_next;
        greater_reg   <= greater_next;
        last_reg      <= last_next;
        out_gb_reg    <= out_gb_next;
        out_total_reg <= out_total_next;
        out_last_reg  <= out_last_next;
        out_ovf_reg   <= out_ovf_next;
    end

    // Index equal to the slot count lives at address zero, which is otherwise unused
    assign ram_rd_addr = pos_reg[VALUE_BITS-1:0];
    assign ram_wr_en   = wr_pend_reg | ctrl.sweep_wr;
    assign ram_wr_addr = ctrl.sweep_wr ? pos_reg[VALUE_BITS-1:0]
                                       : prev_pos_reg[VALUE_BITS-1:0];
    assign ram_wr_data = ctrl.sweep_wr ? '0 : ram_rd_data + CNT_W'(1);

    assign out_valid       = out_valid_reg;
    assign greater_before  = out_gb_reg;
    assign inversion_total = out_total_reg;
    assign is_last_res     = out_last_reg;
    assign overflow        = out_ovf_reg;

endmodule

@@ rtl/fenwick_inversion_counter_unit.sv @@
// Top level of the Fenwick-tree inversion counter.
// The unit takes a sequence of unsigned values, one per input beat, and for each
// returns one output beat: how many earlier values of the sequence were strictly
// greater (saturated at 4095), the running inversion total (saturated at 2^23-1),
// an echo of the last flag and a sticky overflow flag. Counts live in a binary
// indexed tree with one slot per value (low VALUE_BITS bits of the value are used),
// held in a single-port-read, single-port-write RAM. A small microprogram drives
// the datapath: the query walk reads one tree node per cycle and the update walk
// reads one node per cycle while writing back the node read the cycle before, so
// the RAM read port sets the pace. After its accept an item passes the length check,
// the query walk over q nodes (q is the number of set bits of value+1), the count
// step, the update walk over u nodes, the total step, the emit step and the check
// of the last flag; q + u lies between 2 and VALUE_BITS+2. The emit step loads the
// result beat into the output register and stalls while an earlier result is not
// yet taken. Items are handled one at a time; the output register lets the next
// item in while a result still waits to be taken. Once MAX_LEN items have been
// counted, further items are not counted, return zero and hold the total, skipping
// both tree walks. After the beat marked last the tree is cleared by a pass with
// ready low that zeroes every RAM entry; the same pass runs straight after reset.
module fenwick_inversion_counter_unit #(
    parameter int VALUE_BITS = 8,
    parameter int MAX_LEN    = 4096
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [fic_pkg::VAL_W-1:0]    value,
    input  logic                         is_last,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [fic_pkg::GB_W-1:0]     greater_before,
    output logic [fic_pkg::TOTAL_W-1:0]  inversion_total,
    output logic                         is_last_res,
    output logic                         overflow
);
    import fic_pkg::*;

    // Tree counters must hold MAX_LEN itself
    localparam int CNT_W = $clog2(MAX_LEN + 1);

    ctrl_t                  ctrl;
    status_t                status;
    step_t                  step;
    logic [VALUE_BITS-1:0]  ram_rd_addr;
    logic [CNT_W-1:0]       ram_rd_data;
    logic                   ram_wr_en;
    logic [VALUE_BITS-1:0]  ram_wr_addr;
    logic [CNT_W-1:0]       ram_wr_data;

    // Step counter and control store
    fic_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl),
        .step   (step)
    );

    // Count tree, one entry per value slot
    fic_tree_ram #(
        .ADDR_W (VALUE_BITS),
        .DATA_W (CNT_W)
    ) u_tree_ram (
        .clk     (clk),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data)
    );

    // Walk, accumulate, count and present the result beat
    fic_datapath #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_LEN    (MAX_LEN),
        .CNT_W      (CNT_W)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (ctrl),
        .status          (status),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .value           (value),
        .is_last         (is_last),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .greater_before  (greater_before),
        .inversion_total (inversion_total),
        .is_last_res     (is_last_res),
        .overflow        (overflow),
        .ram_rd_addr     (ram_rd_addr),
        .ram_rd_data     (ram_rd_data),
        .ram_wr_en       (ram_wr_en),
        .ram_wr_addr     (ram_wr_addr),
        .ram_wr_data     (ram_wr_data)
    );

    // An accepted beat always goes on to the length check
    a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (step == STEP_CHK))
        else $error("accepted beat did not advance to the length check");

    // A result appears only from the emit step
    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(step == STEP_EMIT))
        else $error("output valid raised outside the emit step");

    // Full sequences must bypass the tree walks
    a_no_count_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (step == STEP_CALC) |-> !status.full)
        else $error("item counted past the maximum length");

endmodule

@@ sim/fenwick_inversion_counter_unit_test.sv @@
// Self-checking testbench for the Fenwick-tree inversion counter unit.
module fenwick_inversion_counter_unit_test;
    import fic_pkg::*;

    localparam int SEQ_MAX_LEN      = 4096;
    localparam int SLOTS            = 1 << VAL_W;
    localparam int LONG_LEN         = 200;
    localparam int RANDOM_PER_PHASE = 150;
    localparam int STUCK_LIMIT      = 4000;
    localparam int DRAIN_CYCLES     = 300;
    localparam int REPORT_LIMIT     = 10;
    localparam int GAP_PCT   [4]    = '{0, 45, 0, 24};
    localparam int STALL_PCT [4]    = '{0, 0, 45, 24};

    typedef struct packed {
        logic [GB_W-1:0]    greater;
        logic [TOTAL_W-1:0] total;
        logic               is_end;
        logic               ovf;
    } beat_t;

    typedef struct {
        logic [VAL_W-1:0] v;
        logic             is_end;
        logic             typed;
        beat_t            want;
    } row_t;

    typedef enum logic [1:0] {
        SPREAD_FULL,
        SPREAD_NARROW,
        SPREAD_FALLING,
        SPREAD_EXTREME
    } spread_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [VAL_W-1:0]    value;
    logic                is_last;
    logic                out_valid;
    logic                out_ready;
    logic [GB_W-1:0]     greater_before;
    logic [TOTAL_W-1:0]  inversion_total;
    logic                is_last_res;
    logic                overflow;

    // Own copy of the counting state
    logic [12:0]         occ_tree [0:SLOTS];
    logic [12:0]         seq_count;
    logic [TOTAL_W-1:0]  inv_sum;
    logic                seq_overflow;

    beat_t               pending_counts [$];
    row_t                directed_rows [0:13];
    int                  send_gap_pct;
    int                  stall_pct;
    int                  mismatches;
    int                  stuck_cycles;
    logic                timed_out;

    fenwick_inversion_counter_unit uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .value           (value),
        .is_last         (is_last),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .greater_before  (greater_before),
        .inversion_total (inversion_total),
        .is_last_res     (is_last_res),
        .overflow        (overflow)
    );

    always #4 clk = ~clk;

    function automatic void clear_counts();
        for (int i = 0; i <= SLOTS; i++)
            occ_tree[i] = '0;
        seq_count    = '0;
        inv_sum      = '0;
        seq_overflow = 1'b0;
    endfunction

    // Advance the counting state by one value and return the beat it yields
    function automatic beat_t count_greater(input logic [VAL_W-1:0] v, input logic lst);
        int          pos;
        logic [12:0] below;
        logic [12:0] greater;
        logic [23:0] sum;
        beat_t       r;
        greater = '0;
        if (seq_count >= 13'(SEQ_MAX_LEN)) begin
            seq_overflow = 1'b1;
        end
        else begin
            below = '0;
            pos   = int'(v) + 1;
            while (pos > 0) begin
                below += occ_tree[pos];
                pos   -= pos & -pos;
            end
            greater = seq_count - below;
            pos     = int'(v) + 1;
            while (pos <= SLOTS) begin
                occ_tree[pos] += 13'(1);
                pos           += pos & -pos;
            end
            seq_count += 13'(1);
            sum     = {1'b0, inv_sum} + 24'(greater);
            inv_sum = (sum > 24'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];
        end
        r.greater = (greater > 13'(GB_MAX)) ? GB_MAX : greater[GB_W-1:0];
        r.total   = inv_sum;
        r.is_end  = lst;
        r.ovf     = seq_overflow;
        if (lst)
            clear_counts();
        return r;
    endfunction

    // Drive one beat from a falling edge and hold it until taken
    task automatic send_item(input logic [VAL_W-1:0] v, input logic lst,
                             input logic typed, input beat_t want);
        beat_t predicted;
        while ($urandom_range(99) < send_gap_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        value    = v;
        is_last  = lst;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = count_greater(v, lst);
        pending_counts = {pending_counts, (typed ? want : predicted)};
        @(negedge clk);
    endtask

    // Random sequences, each closed by a last beat, with a mix of value spreads
    task automatic run_random(input int n_items);
        int               sent;
        int               len;
        int               base;
        int               pick;
        spread_t          spread;
        logic [VAL_W-1:0] v;
        sent = 0;
        while (sent < n_items) begin
            len    = ($urandom_range(15) == 0) ? $urandom_range(300, 100)
                                               : $urandom_range(40, 1);
            spread = spread_t'($urandom_range(3));
            base   = $urandom_range(SLOTS - 8);
            for (int i = 0; i < len; i++) begin
                case (spread)
                    SPREAD_FULL:    pick = $urandom_range(SLOTS - 1);
                    SPREAD_NARROW:  pick = base + $urandom_range(7);
                    SPREAD_FALLING: pick = SLOTS - 1 - (i * SLOTS) / len
                                           - $urandom_range(3);
                    default:        pick = $urandom_range(1) ? SLOTS - 1 : 0;
                endcase
                if (pick < 0)
                    pick = 0;
                v = pick[VAL_W-1:0];
                send_item(v, i == len - 1, 1'b0, '0);
            end
            sent += len;
        end
    endtask

    task automatic check_beat();
        beat_t want;
        if (pending_counts.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: result beat with none pending: ", $time,
                         "gb=%0d total=%0d last=%0b ovf=%0b",
                         greater_before, inversion_total, is_last_res, overflow);
            return;
        end
        want = pending_counts.pop_front();
        if (greater_before !== want.greater || inversion_total !== want.total ||
            is_last_res !== want.is_end || overflow !== want.ovf) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: mismatch: expected gb=%0d total=%0d last=%0b ovf=%0b, ",
                         $time, want.greater, want.total, want.is_end, want.ovf,
                         "got gb=%0d total=%0d last=%0b ovf=%0b",
                         greater_before, inversion_total, is_last_res, overflow);
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            check_beat();
    end

    always @(negedge clk) begin
        out_ready = ($urandom_range(99) >= stall_pct);
    end

    // Count cycles in which neither channel moves a beat
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            stuck_cycles <= 0;
        else if ((in_valid && in_ready) || (out_valid && out_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        value        = '0;
        is_last      = 1'b0;
        out_ready    = 1'b0;
        send_gap_pct = 0;
        stall_pct    = 0;
        mismatches   = 0;
        timed_out    = 1'b0;
        clear_counts();

        // Ten typed rows: values straight after reset, extremes, ties, one-beat sequence
        directed_rows = '{
            '{8'd0,   1'b0, 1'b1, '{12'd0, 23'd0, 1'b0, 1'b0}},
            '{8'd255, 1'b0, 1'b1, '{12'd0, 23'd0, 1'b0, 1'b0}},
            '{8'd0,   1'b0, 1'b1, '{12'd1, 23'd1, 1'b0, 1'b0}},
            '{8'd255, 1'b0, 1'b1, '{12'd0, 23'd1, 1'b0, 1'b0}},
            '{8'd128, 1'b0, 1'b1, '{12'd2, 23'd3, 1'b0, 1'b0}},
            '{8'd128, 1'b1, 1'b1, '{12'd2, 23'd5, 1'b1, 1'b0}},
            '{8'd77,  1'b1, 1'b1, '{12'd0, 23'd0, 1'b1, 1'b0}},
            '{8'd1,   1'b0, 1'b1, '{12'd0, 23'd0, 1'b0, 1'b0}},
            '{8'd1,   1'b0, 1'b1, '{12'd0, 23'd0, 1'b0, 1'b0}},
            '{8'd0,   1'b0, 1'b1, '{12'd2, 23'd2, 1'b0, 1'b0}},
            '{8'd254, 1'b0, 1'b0, '{12'd0, 23'd0, 1'b0, 1'b0}},
            '{8'd170, 1'b0, 1'b0, '{12'd0, 23'd0, 1'b0, 1'b0}},
            '{8'd85,  1'b0, 1'b0, '{12'd0, 23'd0, 1'b0, 1'b0}},
            '{8'd3,   1'b1, 1'b0, '{12'd0, 23'd0, 1'b0, 1'b0}}
        };

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        fork
            begin
                foreach (directed_rows[r])
                    send_item(directed_rows[r].v, directed_rows[r].is_end,
                              directed_rows[r].typed, directed_rows[r].want);

                // One long sequence of falling values, so each beat sees every earlier
                // value as greater and the total climbs steeply
                for (int i = 0; i < LONG_LEN; i++)
                    send_item(8'(SLOTS - 1 - (i * SLOTS) / LONG_LEN), i == LONG_LEN - 1,
                              1'b0, '0);

                for (int p = 0; p < 4; p++) begin
                    send_gap_pct = GAP_PCT[p];
                    stall_pct    = STALL_PCT[p];
                    run_random(RANDOM_PER_PHASE);
                end
                in_valid = 1'b0;

                // Drain, then allow a clearing pass for any stray beat to show
                wait (pending_counts.size() == 0);
                repeat (DRAIN_CYCLES) @(posedge clk);
            end
            begin
                wait (stuck_cycles >= STUCK_LIMIT);
                timed_out = 1'b1;
            end
        join_any

        if (!timed_out && mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/fic_pkg.sv
rtl/fic_seq.sv
rtl/fic_tree_ram.sv
rtl/fic_datapath.sv
rtl/fenwick_inversion_counter_unit.sv
sim/fenwick_inversion_counter_unit_test.sv
